[sv/rpe_pkg.sv]
// Shared types and constants for the rotary position embedding block.
// No dependencies; every other file of the block imports this package.
package rpe_pkg;

   // Row geometry
   localparam int MAX_ROW    = 256;
   localparam int HALF_DEPTH = MAX_ROW / 2;
   localparam int HALF_AW    = $clog2(HALF_DEPTH);
   localparam int POS_W      = 8;
   localparam int LEN_W      = 9;
   localparam int DATA_W     = 16;
   localparam logic [LEN_W-1:0] LEN_CAP =
      LEN_W'(((MAX_ROW < 256) ? MAX_ROW : 256) & ~1);
   localparam logic [LEN_W-1:0] LENGTH_RESET = 9'd64;

   // Queue sizes
   localparam int JOB_DEPTH = 4;
   localparam int JOB_AW    = 2;
   localparam int JOB_CW    = 3;
   localparam int RES_DEPTH = 16;
   localparam int RES_AW    = 4;
   localparam int RES_CW    = 5;

   // Aligned sum width: 16-bit product plus 40 guard bits plus carry
   localparam int MAG_W = 57;

   // Register indexes
   localparam logic CSR_LAYOUT = 1'b0;
   localparam logic CSR_LENGTH = 1'b1;

   typedef enum logic {
      LAYOUT_INTERLEAVED = 1'b0,
      LAYOUT_HALVES      = 1'b1
   } layout_type;

   typedef enum logic [1:0] {
      KIND_FINITE = 2'd0,
      KIND_INF    = 2'd1,
      KIND_NAN    = 2'd2
   } kind_type;

   // Position and flag data that rides along with one rotation
   typedef struct packed {
      logic [POS_W-1:0] pos_lo;
      logic [POS_W-1:0] pos_hi;
      logic             last;
   } meta_type;

   // One rotation: (a, b) against (cos c, sin s)
   typedef struct packed {
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] c;
      logic [DATA_W-1:0] s;
      meta_type          meta;
   } job_type;

   typedef struct packed {
      kind_type          kind;
      logic              sign;
      logic [15:0]       mag;
      logic signed [9:0] exp;
   } prod_type;

   typedef struct packed {
      logic              special;
      logic [15:0]       sbits;
      logic              sign;
      logic [MAG_W-1:0]  mag;
      logic signed [9:0] top;
   } align_type;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] value;
      logic              run_end;
      logic              row_end;
   } result_type;

endpackage

[sv/rpe_front.sv]
// Front end: configuration registers, row position tracking and the row stores.
// Turns accepted elements into rotation jobs. Depends on rpe_pkg.
module rpe_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [8:0]                csr_wdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,
   output logic                      job_push,
   output rpe_pkg::job_type          job_data,
   input  logic [rpe_pkg::JOB_CW-1:0] job_count
);
   import rpe_pkg::*;

   layout_type             layout_ff;
   logic [LEN_W-1:0]       length_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [DATA_W-1:0]      held_el_ff;
   logic [DATA_W-1:0]      held_tw_ff;

   logic [DATA_W-1:0]      half_mem [HALF_DEPTH];
   logic [DATA_W-1:0]      even_mem [HALF_DEPTH];
   logic [DATA_W-1:0]      odd_mem  [HALF_DEPTH];
   logic [DATA_W-1:0]      half_rd_ff;
   logic [DATA_W-1:0]      even_rd_ff;
   logic [DATA_W-1:0]      odd_rd_ff;

   logic                   pend_valid_ff;
   layout_type             pend_mode_ff;
   logic [DATA_W-1:0]      pend_a_ff;
   logic [DATA_W-1:0]      pend_c_ff;
   logic [DATA_W-1:0]      pend_el_ff;
   logic [DATA_W-1:0]      pend_tw_ff;
   logic                   pend_fwd_ff;
   meta_type               pend_meta_ff;
   meta_type               pend_meta_in;

   logic [LEN_W-1:0]       len_even;
   logic [LEN_W-1:0]       len_eff;
   logic [POS_W-1:0]       half;
   logic [POS_W-1:0]       cur_pos;
   logic [POS_W-1:0]       pos_in;
   logic [POS_W-1:0]       k;
   logic                   is_last;
   logic                   upper;
   logic                   accept;
   logic                   emit;
   logic [DATA_W-1:0]      el;
   logic [DATA_W-1:0]      tw;
   logic [JOB_CW-1:0]      used;

   assign el = req_tdata[15:0];
   assign tw = req_tdata[31:16];

   // Effective row length: even, at least two, capped
   always_comb begin
      len_even = length_ff & 9'h1FE;
      if (len_even < 9'd2) begin
         len_eff = 9'd2;
      end else if (len_even > LEN_CAP) begin
         len_eff = LEN_CAP;
      end else begin
         len_eff = len_even;
      end
   end

   assign half    = len_eff[POS_W:1];
   assign cur_pos = ({1'b0, pos_ff} >= len_eff) ? '0 : pos_ff;
   assign is_last = ({1'b0, cur_pos} == (len_eff - 9'd1));
   assign pos_in  = is_last ? '0 : POS_W'(cur_pos + 8'd1);
   assign upper   = (cur_pos >= half);
   assign k       = cur_pos - half;

   // Leave room for a transaction still in the pending register
   assign used       = job_count + JOB_CW'(pend_valid_ff);
   assign req_tready = (used < JOB_CW'(JOB_DEPTH));
   assign accept     = req_tvalid & req_tready;
   assign emit       = accept & ((layout_ff == LAYOUT_INTERLEAVED) ? cur_pos[0] : upper);

   // Configuration and row position
   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff  <= LAYOUT_INTERLEAVED;
         length_ff  <= LENGTH_RESET;
         pos_ff     <= '0;
         held_el_ff <= '0;
         held_tw_ff <= '0;
      end else begin
         if (csr_we) begin
            pos_ff <= '0;
            unique case (csr_index)
               CSR_LAYOUT: layout_ff <= layout_type'(csr_wdata[0]);
               CSR_LENGTH: length_ff <= csr_wdata;
            endcase
         end else if (accept) begin
            pos_ff <= pos_in;
         end
         if (accept && layout_ff == LAYOUT_INTERLEAVED && !cur_pos[0]) begin
            held_el_ff <= el;
            held_tw_ff <= tw;
         end
      end
   end

   // Row stores: write the table word and the first half of the row
   always_ff @(posedge clock) begin
      if (accept && layout_ff == LAYOUT_HALVES) begin
         if (cur_pos[0]) begin
            odd_mem[cur_pos[HALF_AW:1]] <= tw;
         end else begin
            even_mem[cur_pos[HALF_AW:1]] <= tw;
         end
         if (!upper) begin
            half_mem[cur_pos[HALF_AW-1:0]] <= el;
         end
      end
      half_rd_ff <= half_mem[k[HALF_AW-1:0]];
      even_rd_ff <= even_mem[k[HALF_AW-1:0]];
      odd_rd_ff  <= odd_mem[k[HALF_AW-1:0]];
   end

   // Capture the operands while the stores are read
   always_comb begin
      if (layout_ff == LAYOUT_INTERLEAVED) begin
         pend_meta_in.pos_lo = cur_pos - 8'd1;
      end else begin
         pend_meta_in.pos_lo = k;
      end
      pend_meta_in.pos_hi = cur_pos;
      pend_meta_in.last   = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pend_mode_ff <= layout_ff;
         pend_a_ff    <= held_el_ff;
         pend_c_ff    <= held_tw_ff;
         pend_el_ff   <= el;
         pend_tw_ff   <= tw;
         // The last item of the row is itself the sine of the last pair
         pend_fwd_ff  <= (cur_pos == {k[HALF_AW-1:0], 1'b1});
         pend_meta_ff <= pend_meta_in;
      end
   end

   // Form the job from captured and stored operands
   always_comb begin
      job_push      = pend_valid_ff;
      job_data.b    = pend_el_ff;
      job_data.meta = pend_meta_ff;
      if (pend_mode_ff == LAYOUT_INTERLEAVED) begin
         job_data.a = pend_a_ff;
         job_data.c = pend_c_ff;
         job_data.s = pend_tw_ff;
      end else begin
         job_data.a = half_rd_ff;
         job_data.c = even_rd_ff;
         job_data.s = pend_fwd_ff ? pend_tw_ff : odd_rd_ff;
      end
   end

`ifndef SYNTH
   // A job is only formed when the queue had room reserved for it
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (job_count < JOB_CW'(JOB_DEPTH)))
      else $error("job pushed into a full queue");
`endif

endmodule

[sv/rpe_job_queue.sv]
// Short queue of rotation jobs between the front end and the arithmetic back end.
// Depends on rpe_pkg.
module rpe_job_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rpe_pkg::job_type           push_data,
   input  logic                       pop,
   output rpe_pkg::job_type           head,
   output logic [rpe_pkg::JOB_CW-1:0] count
);
   import rpe_pkg::*;

   job_type            mem_ff [JOB_DEPTH];
   logic [JOB_AW-1:0]  wr_ptr_ff;
   logic [JOB_AW-1:0]  rd_ptr_ff;
   logic [JOB_CW-1:0]  count_ff;
   logic [JOB_CW-1:0]  count_in;

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

   always_comb begin
      count_in = count_ff + JOB_CW'(push) - JOB_CW'(pop);
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("job queue popped while empty");
`endif

endmodule

[sv/rpe_back.sv]
// Back end: four-stage bfloat16 rotation datapath and the result queue.
// Multiply, align and add, find the leading one, round. Depends on rpe_pkg.
module rpe_back (
   input  logic                       clock,
   input  logic                       reset,
   input  rpe_pkg::job_type           job_head,
   input  logic [rpe_pkg::JOB_CW-1:0] job_count,
   output logic                       job_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,   // position[7:0], value[23:8]
   output logic                       rsp_tuser,   // run_end
   output logic                       rsp_tlast
);
   import rpe_pkg::*;

   localparam logic [15:0] NAN_BITS = 16'h7FC0;

   // Exact product of two bfloat16 values
   function automatic prod_type f_mul(input logic [15:0] x, input logic [15:0] y);
      prod_type   r;
      logic [7:0] ex;
      logic [7:0] ey;
      logic [6:0] fx;
      logic [6:0] fy;
      logic       xz;
      logic       yz;
      logic [7:0] ex1;
      logic [7:0] ey1;
      ex  = x[14:7];
      ey  = y[14:7];
      fx  = x[6:0];
      fy  = y[6:0];
      xz  = (ex == 8'd0) && (fx == 7'd0);
      yz  = (ey == 8'd0) && (fy == 7'd0);
      ex1 = (ex == 8'd0) ? 8'd1 : ex;
      ey1 = (ey == 8'd0) ? 8'd1 : ey;
      r.sign = x[15] ^ y[15];
      r.mag  = {(ex != 8'd0), fx} * {(ey != 8'd0), fy};
      r.exp  = $signed({2'b00, ex1}) + $signed({2'b00, ey1}) - 10'sd268;
      r.kind = KIND_FINITE;
      if ((ex == 8'hFF && fx != 7'd0) || (ey == 8'hFF && fy != 7'd0)) begin
         r.kind = KIND_NAN;
      end else if (ex == 8'hFF || ey == 8'hFF) begin
         r.kind = (xz || yz) ? KIND_NAN : KIND_INF;
      end
      if (r.kind != KIND_FINITE) begin
         r.mag = '0;
         r.exp = '0;
      end
      return r;
   endfunction

   // Place a product on the common scale of the larger one, keeping a sticky bit
   function automatic logic [MAG_W-1:0] f_align(input logic [15:0] m,
                                                input logic signed [9:0] e,
                                                input logic signed [9:0] top);
      logic signed [10:0] d;
      logic [4:0]         r;
      logic [MAG_W-1:0]   res;
      d = 11'(top) - 11'(e);
      r = '0;
      if (m == 16'd0) begin
         res = '0;
      end else if (d <= 11'sd40) begin
         res = MAG_W'(m) << 6'(11'sd40 - d);
      end else if (d >= 11'sd56) begin
         res = MAG_W'(1);
      end else begin
         r   = 5'(d - 11'sd40);
         res = MAG_W'(m >> r) | MAG_W'(|(m & ((16'd1 << r) - 16'd1)));
      end
      return res;
   endfunction

   // Settle special cases and form the exact signed sum of two products
   function automatic align_type f_sum(input prod_type p1, input prod_type p2);
      align_type        r;
      logic [MAG_W-1:0] u1;
      logic [MAG_W-1:0] u2;
      r.special = 1'b0;
      r.sbits   = '0;
      r.sign    = 1'b0;
      r.mag     = '0;
      if (p1.mag == 16'd0) begin
         r.top = p2.exp;
      end else if (p2.mag == 16'd0) begin
         r.top = p1.exp;
      end else begin
         r.top = (p1.exp > p2.exp) ? p1.exp : p2.exp;
      end
      u1 = f_align(p1.mag, p1.exp, r.top);
      u2 = f_align(p2.mag, p2.exp, r.top);
      priority if (p1.kind == KIND_NAN || p2.kind == KIND_NAN) begin
         r.special = 1'b1;
         r.sbits   = NAN_BITS;
      end else if (p1.kind == KIND_INF && p2.kind == KIND_INF && p1.sign != p2.sign) begin
         r.special = 1'b1;
         r.sbits   = NAN_BITS;
      end else if (p1.kind == KIND_INF) begin
         r.special = 1'b1;
         r.sbits   = {p1.sign, 15'h7F80};
      end else if (p2.kind == KIND_INF) begin
         r.special = 1'b1;
         r.sbits   = {p2.sign, 15'h7F80};
      end else if (p1.mag == 16'd0 && p2.mag == 16'd0) begin
         r.special = 1'b1;
         r.sbits   = {p1.sign & p2.sign, 15'd0};
      end else if (p1.sign == p2.sign) begin
         r.mag  = u1 + u2;
         r.sign = p1.sign;
      end else if (u1 >= u2) begin
         r.mag  = u1 - u2;
         r.sign = p1.sign;
      end else begin
         r.mag  = u2 - u1;
         r.sign = p2.sign;
      end
      return r;
   endfunction

   // Index of the leading one
   function automatic logic [5:0] f_msb(input logic [MAG_W-1:0] m);
      logic [5:0] idx;
      idx = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (m[i]) begin
            idx = 6'(i);
         end
      end
      return idx;
   endfunction

   // Round to nearest even and pack as bfloat16
   function automatic logic [15:0] f_round(input align_type x, input logic [5:0] msb);
      logic signed [11:0] t;
      logic signed [11:0] s;
      logic signed [11:0] ns;
      logic signed [11:0] ef;
      logic [63:0]        m64;
      logic [63:0]        q64;
      logic [5:0]         sv;
      logic               rbit;
      logic               sticky;
      logic               inc;
      logic [8:0]         q;
      logic [15:0]        res;
      t      = $signed({6'b0, msb}) + 12'(x.top) - 12'sd47;
      m64    = 64'(x.mag);
      q64    = '0;
      sv     = '0;
      rbit   = 1'b0;
      sticky = 1'b0;
      inc    = 1'b0;
      q      = '0;
      ef     = '0;
      if (t < -12'sd133) begin
         t = -12'sd133;
      end
      s  = t - 12'(x.top) + 12'sd40;
      ns = -s;
      if (s <= 12'sd0) begin
         q64 = m64 << ns[5:0];
         q   = q64[8:0];
      end else if (s < 12'sd58) begin
         sv     = s[5:0];
         q64    = m64 >> sv;
         rbit   = m64[sv - 6'd1];
         sticky = |(m64 & ((64'd1 << (sv - 6'd1)) - 64'd1));
         inc    = rbit & (sticky | q64[0]);
         q      = q64[8:0] + 9'(inc);
      end
      if (q[8]) begin
         q = q >> 1;
         t = t + 12'sd1;
      end
      ef = t + 12'sd134;
      if (x.special) begin
         res = x.sbits;
      end else if (x.mag == '0) begin
         res = '0;
      end else if (!q[7]) begin
         res = {x.sign, 8'd0, q[6:0]};
      end else if (ef >= 12'sd255) begin
         res = {x.sign, 15'h7F80};
      end else begin
         res = {x.sign, ef[7:0], q[6:0]};
      end
      return res;
   endfunction

   // Pipeline registers
   logic              v_p_ff;
   logic              v_a_ff;
   logic              v_l_ff;
   logic              v_r_ff;
   prod_type          prod_ff [4];
   align_type         al1_ff;
   align_type         al2_ff;
   align_type         al1_l_ff;
   align_type         al2_l_ff;
   logic [5:0]        msb1_ff;
   logic [5:0]        msb2_ff;
   logic [15:0]       val1_ff;
   logic [15:0]       val2_ff;
   meta_type          meta_p_ff;
   meta_type          meta_a_ff;
   meta_type          meta_l_ff;
   meta_type          meta_r_ff;
   prod_type          bs;

   // Result queue
   result_type        res_mem_ff [RES_DEPTH];
   logic [RES_AW-1:0] res_wr_ff;
   logic [RES_AW-1:0] res_rd_ff;
   logic [RES_CW-1:0] res_count_ff;
   logic [RES_CW-1:0] res_count_in;
   logic [2:0]        inflight;
   logic [5:0]        need;
   logic              rsp_pop;
   result_type        r_first;
   result_type        r_second;
   result_type        r_head;

   // Take a job only when the results of all jobs in flight are sure of room
   assign inflight = 3'(v_p_ff) + 3'(v_a_ff) + 3'(v_l_ff) + 3'(v_r_ff);
   assign need     = 6'(res_count_ff) + {2'b00, inflight, 1'b0} + 6'd2;
   assign job_pop  = (job_count != '0) && (need <= 6'(RES_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_p_ff <= 1'b0;
         v_a_ff <= 1'b0;
         v_l_ff <= 1'b0;
         v_r_ff <= 1'b0;
      end else begin
         v_p_ff <= job_pop;
         v_a_ff <= v_p_ff;
         v_l_ff <= v_a_ff;
         v_r_ff <= v_l_ff;
      end
   end

   // Multiply: b*s enters the first sum negated
   always_comb begin
      bs      = f_mul(job_head.b, job_head.s);
      bs.sign = ~bs.sign;
   end

   always_ff @(posedge clock) begin
      prod_ff[0] <= f_mul(job_head.a, job_head.c);
      prod_ff[1] <= bs;
      prod_ff[2] <= f_mul(job_head.a, job_head.s);
      prod_ff[3] <= f_mul(job_head.b, job_head.c);
      meta_p_ff  <= job_head.meta;
   end

   // Align and add, one lane per output of the pair
   always_ff @(posedge clock) begin
      al1_ff    <= f_sum(prod_ff[0], prod_ff[1]);
      al2_ff    <= f_sum(prod_ff[2], prod_ff[3]);
      meta_a_ff <= meta_p_ff;
   end

   // Leading one
   always_ff @(posedge clock) begin
      al1_l_ff  <= al1_ff;
      al2_l_ff  <= al2_ff;
      msb1_ff   <= f_msb(al1_ff.mag);
      msb2_ff   <= f_msb(al2_ff.mag);
      meta_l_ff <= meta_a_ff;
   end

   // Round
   always_ff @(posedge clock) begin
      val1_ff   <= f_round(al1_l_ff, msb1_ff);
      val2_ff   <= f_round(al2_l_ff, msb2_ff);
      meta_r_ff <= meta_l_ff;
   end

   // Both results of a pair enter the queue together
   always_comb begin
      r_first.position  = meta_r_ff.pos_lo;
      r_first.value     = val1_ff;
      r_first.run_end   = 1'b0;
      r_first.row_end   = 1'b0;
      r_second.position = meta_r_ff.pos_hi;
      r_second.value    = val2_ff;
      r_second.run_end  = 1'b1;
      r_second.row_end  = meta_r_ff.last;
   end

   assign rsp_tvalid   = (res_count_ff != '0);
   assign rsp_pop      = rsp_tvalid & rsp_tready;
   assign res_count_in = res_count_ff + (v_r_ff ? RES_CW'(2) : '0) - RES_CW'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff    <= '0;
         res_rd_ff    <= '0;
         res_count_ff <= '0;
      end else begin
         if (v_r_ff) begin
            res_wr_ff <= res_wr_ff + 4'd2;
         end
         if (rsp_pop) begin
            res_rd_ff <= res_rd_ff + 4'd1;
         end
         res_count_ff <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (v_r_ff) begin
         res_mem_ff[res_wr_ff]        <= r_first;
         res_mem_ff[res_wr_ff + 4'd1] <= r_second;
      end
   end

   assign r_head    = res_mem_ff[res_rd_ff];
   assign rsp_tdata = {r_head.value, r_head.position};
   assign rsp_tuser = r_head.run_end;
   assign rsp_tlast = r_head.row_end;

`ifndef SYNTH
   a_res_bound: assert property (@(posedge clock) disable iff (reset)
      res_count_ff <= RES_CW'(RES_DEPTH))
      else $error("result queue overflow");
   a_row_end_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("row end without run end");
   a_credit: assert property (@(posedge clock) disable iff (reset)
      v_r_ff |-> (res_count_ff <= RES_CW'(RES_DEPTH - 2)))
      else $error("pair arrived without room");
`endif

endmodule

[sv/rotary_position_embedding.sv]
// Rotary position embedding, top level: front end, job queue and back end.
// Depends on rpe_pkg, rpe_front, rpe_job_queue and rpe_back.
//
// Usage:
//   req_* carries one row element and its table word per transaction
//   (cos at even positions, sin at odd). rsp_* returns rotated bfloat16
//   values, each tagged with its row position; tuser marks the last result
//   of the input transaction that caused it, tlast the last result of a row.
//   csr_* writes layout_mode (index 0) and row_length (index 1); any write
//   restarts the row at position 0. Write only while the block is idle.
// Throughput: one input transaction per cycle while req_tready is high; a
//   completing item yields two results, drained at one per cycle while rsp_tready
//   is high, from a 16-entry result queue. From the completing input to its first
//   result: operand fetch, queue, multiply, align/add, leading one, round.
// Reset: synchronous; interleaved layout, row length 64, queues empty.
//   The row stores are not cleared; every entry read is written earlier.
// Stall: while rsp_tready is low results collect in the result queue; the
//   back end stops taking jobs when the queue has no room, the job queue
//   fills and req_tready drops. No result is lost.
module rotary_position_embedding (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // element[15:0], table_word[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // position[7:0], value[23:8]
   output logic        rsp_tuser,   // run_end
   output logic        rsp_tlast
);
   import rpe_pkg::*;

   logic              job_push;
   job_type           job_data;
   logic              job_pop;
   job_type           job_head;
   logic [JOB_CW-1:0] job_count;

   rpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .job_push   (job_push),
      .job_data   (job_data),
      .job_count  (job_count)
   );

   rpe_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .pop       (job_pop),
      .head      (job_head),
      .count     (job_count)
   );

   rpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_head   (job_head),
      .job_count  (job_count),
      .job_pop    (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[tb/tb_rotary_position_embedding.sv]
`timescale 1ns / 100ps
// Self-checking testbench for rotary_position_embedding: bfloat16 pair rotation
// checked against an in-bench predictor over both layouts. Depends on rpe_pkg.
module tb_rotary_position_embedding;
   import rpe_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 24;
   localparam int LONG_HOLD   = 400;
   localparam logic [15:0] QNAN = 16'h7FC0;

   typedef struct {
      kind_type           kind;
      bit                 sign;
      longint unsigned    mag;
      int                 exp;
   } product_type;

   typedef struct {
      bit          pause;
      logic [15:0] element;
      logic [15:0] table_word;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [8:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // element[15:0], table_word[31:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // position[7:0], value[23:8]
   logic        rsp_tuser;        // run_end
   logic        rsp_tlast;

   rotary_position_embedding dut (.*);

   always #1 clock = ~clock;

   // Predictor state
   layout_type  mdl_layout = LAYOUT_INTERLEAVED;
   logic [8:0]  mdl_length = LENGTH_RESET;
   int unsigned mdl_pos = 0;
   logic [15:0] held_el = '0, held_tw = '0;
   logic [15:0] half_mem [MAX_ROW/2];
   logic [15:0] tab_mem [MAX_ROW];

   stim_type   pending_q[$];
   result_type rotated_q[$];
   int         mismatches = 0;
   int         cycles = 0;
   int         hold_req = 0, hold_served = 0, hold_left = 0;

   // Exact bfloat16 product
   function automatic product_type bf_product(logic [15:0] x, logic [15:0] y);
      product_type r;
      logic [7:0] ex, ey;
      logic [6:0] fx, fy;
      bit xz, yz;
      ex = x[14:7]; fx = x[6:0]; ey = y[14:7]; fy = y[6:0];
      xz = (ex == 0 && fx == 0); yz = (ey == 0 && fy == 0);
      r.sign = x[15] ^ y[15];
      r.mag = 0; r.exp = 0; r.kind = KIND_FINITE;
      if ((ex == 8'hFF && fx != 0) || (ey == 8'hFF && fy != 0)) begin
         r.kind = KIND_NAN;
         return r;
      end
      if (ex == 8'hFF || ey == 8'hFF) begin
         r.kind = (xz || yz) ? KIND_NAN : KIND_INF;
         return r;
      end
      r.mag = longint'(ex != 0 ? {1'b1, fx} : {1'b0, fx}) *
              longint'(ey != 0 ? {1'b1, fy} : {1'b0, fy});
      r.exp = (int'(ex != 0 ? ex : 8'd1) - 134) + (int'(ey != 0 ? ey : 8'd1) - 134);
      return r;
   endfunction

   // Shift a product onto the common grid, folding lost bits into a sticky bit
   function automatic longint unsigned align_to(product_type p, int top);
      int sh;
      if (p.mag == 0) return 0;
      sh = 40 + p.exp - top;
      if (sh >= 0) return p.mag << sh;
      sh = -sh;
      if (sh >= 63) return 1;
      return (p.mag >> sh) | ((p.mag & ((64'd1 << sh) - 1)) != 0 ? 64'd1 : 64'd0);
   endfunction

   // Sum two exact products, round once to nearest even
   function automatic logic [15:0] bf_add_round(product_type p1, product_type p2);
      int top, base, msb, t, s;
      longint unsigned u1, u2, mag, q, rem, hf;
      bit sg;
      int unsigned ef;
      if (p1.kind == KIND_NAN || p2.kind == KIND_NAN) return QNAN;
      if (p1.kind == KIND_INF && p2.kind == KIND_INF && p1.sign != p2.sign) return QNAN;
      if (p1.kind == KIND_INF) return {p1.sign, 15'h7F80};
      if (p2.kind == KIND_INF) return {p2.sign, 15'h7F80};
      if (p1.mag == 0 && p2.mag == 0) return {p1.sign & p2.sign, 15'h0};
      if (p1.mag == 0) top = p2.exp;
      else if (p2.mag == 0) top = p1.exp;
      else top = (p1.exp > p2.exp) ? p1.exp : p2.exp;
      u1 = align_to(p1, top);
      u2 = align_to(p2, top);
      if (p1.sign == p2.sign) begin
         mag = u1 + u2; sg = p1.sign;
      end else if (u1 >= u2) begin
         mag = u1 - u2; sg = p1.sign;
      end else begin
         mag = u2 - u1; sg = p2.sign;
      end
      if (mag == 0) return 16'h0000;
      base = top - 40;
      msb = 63;
      while (mag[msb] == 1'b0) msb--;
      t = msb + base - 7;
      if (t < -133) t = -133;
      s = t - base;
      if (s <= 0) q = mag << (-s);
      else if (s >= 58) q = 0;
      else begin
         rem = mag & ((64'd1 << s) - 1);
         hf = 64'd1 << (s - 1);
         q = mag >> s;
         if (rem > hf || (rem == hf && q[0])) q++;
      end
      if (q >= 64'h100) begin
         q >>= 1; t++;
      end
      if (q < 64'h80) return {sg, q[14:0]};
      ef = t + 134;
      if (ef >= 255) return {sg, 15'h7F80};
      return {sg, ef[7:0], q[6:0]};
   endfunction

   // Advance the row by one element and queue the results it completes
   task automatic rotate_item(logic [15:0] el, logic [15:0] tw);
      int unsigned len, half, p, k;
      bit last;
      logic [15:0] a, c, sn;
      product_type bs;
      result_type r;
      len = mdl_length & 9'h1FE;
      if (len < 2) len = 2;
      if (len > LEN_CAP) len = LEN_CAP;
      half = len / 2;
      p = (mdl_pos >= len) ? 0 : mdl_pos;
      last = (p == len - 1);
      mdl_pos = last ? 0 : ((p + 1) & 8'hFF);
      if (mdl_layout == LAYOUT_INTERLEAVED) begin
         if (p[0] == 1'b0) begin
            held_el = el; held_tw = tw;
            return;
         end
         a = held_el; c = held_tw; sn = tw; k = p - 1;
      end else begin
         tab_mem[p] = tw;
         if (p < half) begin
            half_mem[p] = el;
            return;
         end
         k = p - half;
         a = half_mem[k]; c = tab_mem[2*k]; sn = tab_mem[2*k+1];
      end
      bs = bf_product(el, sn);
      bs.sign ^= 1'b1;
      r.position = k[7:0];
      r.value = bf_add_round(bf_product(a, c), bs);
      r.run_end = 1'b0; r.row_end = 1'b0;
      rotated_q.push_back(r);
      r.position = p[7:0];
      r.value = bf_add_round(bf_product(a, sn), bf_product(el, c));
      r.run_end = 1'b1; r.row_end = last;
      rotated_q.push_back(r);
   endtask

   // Bias toward special encodings and values near one
   function automatic logic [15:0] pick_bf16();
      logic [15:0] v;
      v = 16'($urandom());
      case ($urandom_range(0, 9))
         0: v[14:7] = 8'h00;
         1: v[14:7] = 8'hFF;
         2: v[14:0] = 15'h0;
         3: v[14:7] = 8'($urandom_range(1, 8));
         4: v[14:7] = 8'($urandom_range(246, 254));
         5, 6, 7: v[14:7] = 8'($urandom_range(118, 132));
         default: ;
      endcase
      return v;
   endfunction

   task automatic push_item(logic [15:0] el, logic [15:0] tw);
      stim_type st;
      st.pause = 1'b0; st.element = el; st.table_word = tw;
      pending_q.push_back(st);
   endtask

   task automatic push_pause();
      stim_type st;
      st.pause = 1'b1; st.element = '0; st.table_word = '0;
      pending_q.push_back(st);
   endtask

   // Wait until every offered transaction is taken and every result is back
   task automatic wait_idle();
      while (pending_q.size() != 0 || req_tvalid || rotated_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [8:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      if (idx == CSR_LAYOUT) mdl_layout = layout_type'(val[0]);
      else mdl_length = val;
      mdl_pos = 0;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Sender: bursts of random length separated by random gaps
   int burst_left = 0, gap_left = 0, gap_max = 4;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rotate_item(req_tdata[15:0], req_tdata[31:16]);
            void'(pending_q.pop_front());
         end
         if (pending_q.size() != 0 && pending_q[0].pause && rotated_q.size() == 0)
            void'(pending_q.pop_front());
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = $urandom_range(0, gap_max);
               if ($urandom_range(0, 3) == 0) gap_max = $urandom_range(0, 1) ? 0 : 8;
            end
            if (gap_left == 0 && pending_q.size() != 0 && !pending_q[0].pause) begin
               req_tvalid <= 1'b1;
               req_tdata <= {pending_q[0].table_word, pending_q[0].element};
               burst_left--;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      else if (hold_req != hold_served) begin
         hold_served <= hold_req;
         hold_left <= LONG_HOLD;
      end
   end

   // Receiver: check each result transaction against the oldest expectation
   int ready_mode = 0, mode_left = 0;
   result_type got, want;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.position = rsp_tdata[7:0];
         got.value = rsp_tdata[23:8];
         got.run_end = rsp_tuser;
         got.row_end = rsp_tlast;
         if (rotated_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %p", got);
         end else begin
            want = rotated_q.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, got);
            end
         end
      end
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(8, 80);
      end else mode_left--;
      case (ready_mode)
         0: rsp_tready <= (hold_left == 0);
         1: rsp_tready <= ($urandom_range(0, 1) == 1) && hold_left == 0;
         2: rsp_tready <= ($urandom_range(0, 3) == 0) && hold_left == 0;
         default: rsp_tready <= ($urandom_range(0, 7) != 0) && hold_left == 0;
      endcase
   end

   // Stimulus sequence
   logic [8:0] len_set [12] = '{9'd2, 9'd2, 9'd256, 9'd256, 9'd0, 9'd1,
                                9'd511, 9'd300, 9'd7, 9'd4, 9'd258, 9'd130};
   int total = 0;
   int n_items;
   logic [15:0] specials [12] = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0,
                                  16'h0001, 16'h807F, 16'h7F7F, 16'hFF7F, 16'h3F80,
                                  16'h0080, 16'hBF80};
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset setting (interleaved, 64), special operand pairs
      push_item(16'h3F80, 16'h3F80); push_item(16'h3F80, 16'h0000);  // plain
      push_item(16'h7F80, 16'h0000); push_item(16'h3F80, 16'h3F80);  // inf times zero
      push_item(16'h7FC1, 16'h3F80); push_item(16'h3F80, 16'h3F80);  // NaN operand
      push_item(16'h7F80, 16'h3F80); push_item(16'h7F80, 16'h3F80);  // opposite infinities
      push_item(16'h3F80, 16'h3F80); push_item(16'h3F80, 16'h3F80);  // exact cancellation
      push_item(16'h8000, 16'h0000); push_item(16'h0000, 16'h8000);  // signed zero sums
      push_item(16'h7F7F, 16'h7F7F); push_item(16'h7F7F, 16'hFF7F);  // overflow
      push_item(16'h0080, 16'h0080); push_item(16'h0001, 16'h0080);  // underflow
      push_item(16'h0001, 16'h3F80); push_item(16'h807F, 16'h3F80);  // subnormal operands
      push_item(16'hFFFF, 16'hFFFF); push_item(16'hFFFF, 16'hFFFF);  // all ones
      push_item(16'h3F81, 16'h3F80); push_item(16'h3B80, 16'h3F80);  // rounding ties
      wait_idle();

      for (int ph = 0; total < 1250; ph++) begin
         if (ph < 12) begin
            csr_write(CSR_LAYOUT, 9'(ph % 2 == 0));
            csr_write(CSR_LENGTH, len_set[ph]);
         end else begin
            csr_write(CSR_LENGTH, 9'($urandom_range(0, 511)));
            csr_write(CSR_LAYOUT, 9'($urandom_range(0, 1)));
         end
         if (ph == 3) hold_req++;
         n_items = (ph == 2 || ph == 3) ? 300 : $urandom_range(20, 110);
         for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 9) == 0)
               push_item(specials[$urandom_range(0, 11)], specials[$urandom_range(0, 11)]);
            else
               push_item(pick_bf16(), pick_bf16());
            if (i == n_items / 2 && $urandom_range(0, 2) == 0) push_pause();
            if (ph == 3 && i == 250) hold_req++;
         end
         total += n_items;
         wait_idle();
      end

      wait_idle();
      mismatches += rotated_q.size();
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
sv/rpe_pkg.sv
sv/rpe_front.sv
sv/rpe_job_queue.sv
sv/rpe_back.sv
sv/rotary_position_embedding.sv
tb/tb_rotary_position_embedding.sv
